// ===== sv/gpbmd_pkg.sv =====
// shared types and constants for the pushbuffer method decoder
`default_nettype none

package gpbmd_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned METHOD_W = 13;
    localparam int unsigned SUBCH_W  = 3;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned MODE_W   = 3;

    localparam int unsigned METHOD_LSB = 0;
    localparam int unsigned SUBCH_LSB  = 13;
    localparam int unsigned COUNT_LSB  = 16;
    localparam int unsigned MODE_LSB   = 29;

    localparam logic [MODE_W-1:0] MODE_INCREASING = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NONINCR    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INLINE     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_INC_ONCE   = 3'd5;

    localparam logic [METHOD_W-1:0] LIMIT_RESET = 13'd64;

    typedef struct packed {
        logic [METHOD_W-1:0] cur_method;
        logic [SUBCH_W-1:0]  cur_subchannel;
        logic [COUNT_W-1:0]  words_left;
        logic                hold_method;
        logic                hold_after_first;
    } run_state_t;

    typedef struct packed {
        logic [METHOD_W-1:0] method_addr;
        logic [SUBCH_W-1:0]  subchannel;
        logic [WORD_W-1:0]   argument;
        logic                to_puller;
        logic                last_in_run;
        logic [COUNT_W-1:0]  remaining_count;
    } call_t;

endpackage

`default_nettype wire

// ===== sv/gpbmd_if.sv =====
// valid/ready channel interfaces for command words and method calls
`default_nettype none

interface gpbmd_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [gpbmd_pkg::WORD_W-1:0]    cmd_word;

    modport source (output valid, output cmd_word, input ready);
    modport sink (input valid, input cmd_word, output ready);
endinterface

interface gpbmd_call_if;
    logic                            valid;
    logic                            ready;
    logic [gpbmd_pkg::METHOD_W-1:0]  method_addr;
    logic [gpbmd_pkg::SUBCH_W-1:0]   subchannel;
    logic [gpbmd_pkg::WORD_W-1:0]    argument;
    logic                            to_puller;
    logic                            last_in_run;
    logic [gpbmd_pkg::COUNT_W-1:0]   remaining_count;

    modport source (output valid, output method_addr, output subchannel, output argument,
                    output to_puller, output last_in_run, output remaining_count,
                    input ready);
    modport sink (input valid, input method_addr, input subchannel, input argument,
                  input to_puller, input last_in_run, input remaining_count,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/gpbmd_decode.sv =====
// header and data word decode with next run state
`default_nettype none

module gpbmd_decode (
    input  wire logic [gpbmd_pkg::WORD_W-1:0]   word,
    input  wire logic [gpbmd_pkg::METHOD_W-1:0] limit,
    input  wire gpbmd_pkg::run_state_t          state,
    output gpbmd_pkg::run_state_t               state_next,
    output logic                                emit,
    output gpbmd_pkg::call_t                    call
);

    logic [gpbmd_pkg::METHOD_W-1:0] hdr_method;
    logic [gpbmd_pkg::SUBCH_W-1:0]  hdr_subch;
    logic [gpbmd_pkg::COUNT_W-1:0]  hdr_count;
    logic [gpbmd_pkg::MODE_W-1:0]   hdr_mode;

    assign hdr_method = word[gpbmd_pkg::METHOD_LSB +: gpbmd_pkg::METHOD_W];
    assign hdr_subch  = word[gpbmd_pkg::SUBCH_LSB +: gpbmd_pkg::SUBCH_W];
    assign hdr_count  = word[gpbmd_pkg::COUNT_LSB +: gpbmd_pkg::COUNT_W];
    assign hdr_mode   = word[gpbmd_pkg::MODE_LSB +: gpbmd_pkg::MODE_W];

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        call       = '0;
        if (state.words_left != '0)
        begin
            // data word of an open run
            emit                 = 1'b1;
            call.method_addr     = state.cur_method;
            call.subchannel      = state.cur_subchannel;
            call.argument        = word;
            call.to_puller       = state.cur_method < limit;
            call.last_in_run     = state.words_left == gpbmd_pkg::COUNT_W'(1);
            call.remaining_count = state.words_left;
            if (!state.hold_method)
            begin
                state_next.cur_method = state.cur_method + gpbmd_pkg::METHOD_W'(1);
            end
            if (state.hold_after_first)
            begin
                state_next.hold_method = 1'b1;
            end
            state_next.words_left = state.words_left - gpbmd_pkg::COUNT_W'(1);
        end
        else
        begin
            unique case (hdr_mode) inside
                gpbmd_pkg::MODE_INCREASING, gpbmd_pkg::MODE_NONINCR,
                gpbmd_pkg::MODE_INC_ONCE:
                begin
                    state_next.cur_method       = hdr_method;
                    state_next.cur_subchannel   = hdr_subch;
                    state_next.words_left       = hdr_count;
                    state_next.hold_method      = hdr_mode == gpbmd_pkg::MODE_NONINCR;
                    state_next.hold_after_first = hdr_mode == gpbmd_pkg::MODE_INC_ONCE;
                end
                gpbmd_pkg::MODE_INLINE:
                begin
                    state_next.cur_method       = hdr_method;
                    state_next.cur_subchannel   = hdr_subch;
                    state_next.hold_method      = 1'b1;
                    state_next.hold_after_first = 1'b0;
                    emit                 = 1'b1;
                    call.method_addr     = hdr_method;
                    call.subchannel      = hdr_subch;
                    call.argument        = gpbmd_pkg::WORD_W'(hdr_count);
                    call.to_puller       = hdr_method < limit;
                    call.last_in_run     = 1'b1;
                    call.remaining_count = '0;
                end
                default:
                begin
                    // unknown mode, word dropped
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/gpu_pushbuffer_method_decoder.sv =====
// top level of the pushbuffer method decoder
`default_nettype none

// Takes one command word per cycle while the output is not stalled and turns it into at
// most one method call. A word goes into an input register, is decoded against the run
// state (method, subchannel, words left, hold flags) and the call lands in an output
// register; a new word can be taken every cycle unless call.ready holds the output.
// Headers other than inline ones and words of unknown mode produce no call. The user
// must write the puller limit through cfg_we/cfg_wdata only while no word is in flight;
// the block does not enforce it.
module gpu_pushbuffer_method_decoder (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [gpbmd_pkg::METHOD_W-1:0] cfg_wdata,
    gpbmd_cmd_if.sink                           cmd,
    gpbmd_call_if.source                        call
);

    logic [gpbmd_pkg::METHOD_W-1:0] limit_reg;
    logic                           in_valid_reg;
    logic [gpbmd_pkg::WORD_W-1:0]   in_word_reg;
    gpbmd_pkg::run_state_t          state_reg;
    gpbmd_pkg::run_state_t          state_next;
    logic                           out_valid_reg;
    gpbmd_pkg::call_t               out_reg;

    logic                           dec_emit;
    gpbmd_pkg::call_t               dec_call;
    logic                           out_free;
    logic                           stage_go;

    gpbmd_decode u_decode (
        .word       (in_word_reg),
        .limit      (limit_reg),
        .state      (state_reg),
        .state_next (state_next),
        .emit       (dec_emit),
        .call       (dec_call)
    );

    assign out_free  = !out_valid_reg || call.ready;
    assign stage_go  = in_valid_reg && out_free;
    assign cmd.ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= gpbmd_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            in_word_reg <= cmd.cmd_word;
        end
    end

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (stage_go)
        begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= stage_go && dec_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && dec_emit)
        begin
            out_reg <= dec_call;
        end
    end

    assign call.valid           = out_valid_reg;
    assign call.method_addr     = out_reg.method_addr;
    assign call.subchannel      = out_reg.subchannel;
    assign call.argument        = out_reg.argument;
    assign call.to_puller       = out_reg.to_puller;
    assign call.last_in_run     = out_reg.last_in_run;
    assign call.remaining_count = out_reg.remaining_count;

    // data words always produce a call
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_go && state_reg.words_left != '0 |=> out_valid_reg)
        else $error("data word produced no call");

    // run count steps down by one per data word
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_go && state_reg.words_left != '0
        |=> state_reg.words_left == $past(state_reg.words_left) - gpbmd_pkg::COUNT_W'(1))
        else $error("words left did not decrement");

    // held method stays put across data words
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_go && state_reg.words_left != '0 && state_reg.hold_method
        |=> state_reg.cur_method == $past(state_reg.cur_method))
        else $error("held method advanced");

    // last flag only on final call of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.remaining_count > gpbmd_pkg::COUNT_W'(1)
        |-> !out_reg.last_in_run)
        else $error("last flag set early");

endmodule

`default_nettype wire
